// File: design/selective_repeat_sender_defines.svh
`ifndef SELECTIVE_REPEAT_SENDER_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define SRS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is low.
`define SRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: design/srs_pkg.sv
package srs_pkg;

  // SLOTS must be a power of two that divides 2^SEQ_BITS.
  localparam int SLOTS        = 8;
  localparam int SEQ_BITS     = 16;
  localparam int PAYLOAD_BITS = 64;

  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = SEQ_BITS + 1;
  localparam int OP_W     = 2;
  localparam int SEQ_IO_W = 16;
  localparam int PAY_IO_W = 64;
  localparam int WIN_W    = 4;
  localparam int ACT_W    = 2;
  localparam int OUTC_W   = 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [ACT_W-1:0] TMR_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] TMR_START   = 2'd1;
  localparam logic [ACT_W-1:0] TMR_STOP    = 2'd2;
  localparam logic [ACT_W-1:0] TMR_RESTART = 2'd3;

  localparam logic [OUTC_W-1:0] ACK_NONE    = 2'd0;
  localparam logic [OUTC_W-1:0] ACK_SLID    = 2'd1;
  localparam logic [OUTC_W-1:0] ACK_MARKED  = 2'd2;
  localparam logic [OUTC_W-1:0] ACK_IGNORED = 2'd3;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_SLIDE,
    KIND_READ
  } srs_kind_e;

  typedef struct packed {
    logic capture;
    logic resolve;
    logic load_tx;
    logic slide;
    logic slide_end;
    logic emit;
  } srs_cmd_t;

  typedef struct packed {
    srs_kind_e kind;
    logic      slide_more;
    logic      emit_ok;
  } srs_sts_t;

  typedef struct packed {
    logic                    accepted;
    logic                    tx_valid;
    logic [SEQ_BITS-1:0]     tx_seq;
    logic [PAYLOAD_BITS-1:0] tx_payload;
    logic [ACT_W-1:0]        timer_action;
    logic [SEQ_BITS-1:0]     timer_seq;
    logic [OUTC_W-1:0]       ack_outcome;
  } srs_res_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [SEQ_BITS-1:0] s);
    return s[SLOT_W-1:0];
  endfunction

endpackage

// File: design/srs_in_if.sv
interface srs_in_if import srs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [PAY_IO_W-1:0] payload_word;
  logic [SEQ_IO_W-1:0] seq_num;
  logic                ack_intact;

  modport source (output valid, op, payload_word, seq_num, ack_intact, input ready);
  modport sink (input valid, op, payload_word, seq_num, ack_intact, output ready);
endinterface

// File: design/srs_out_if.sv
interface srs_out_if import srs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                accepted;
  logic                tx_valid;
  logic [SEQ_IO_W-1:0] tx_seq;
  logic [PAY_IO_W-1:0] tx_payload;
  logic [ACT_W-1:0]    timer_action;
  logic [SEQ_IO_W-1:0] timer_seq;
  logic [OUTC_W-1:0]   ack_outcome;
  logic                window_full;

  modport source (output valid, accepted, tx_valid, tx_seq, tx_payload, timer_action,
                  timer_seq, ack_outcome, window_full, input ready);
  modport sink (input valid, accepted, tx_valid, tx_seq, tx_payload, timer_action,
                timer_seq, ack_outcome, window_full, output ready);
endinterface

// File: design/srs_cfg_if.sv
interface srs_cfg_if import srs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_size;

  modport source (output valid, window_size, input ready);
  modport sink (input valid, window_size, output ready);
endinterface

// File: design/srs_ram.sv
module srs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/srs_ctrl.sv
`include "selective_repeat_sender_defines.svh"

module srs_ctrl import srs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  srs_sts_t sts_i,
  output srs_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SLIDE  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.resolve = 1'b1;
        case (sts_i.kind)
          KIND_SLIDE: state_d = S_SLIDE;
          KIND_READ:  state_d = S_RDWAIT;
          default:    state_d = S_EMIT;
        endcase
      end
      S_RDWAIT: begin
        cmd_o.load_tx = 1'b1;
        state_d       = S_EMIT;
      end
      S_SLIDE: begin
        // advance base one slot a cycle while the slot at base is acknowledged
        if (sts_i.slide_more) begin
          cmd_o.slide = 1'b1;
        end else begin
          cmd_o.slide_end = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SRS_ASSERT_NEXT(a_accept_to_exec, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_EXEC)
  `SRS_ASSERT_IMP(a_emit_only_when_free, clk_i, rst_ni, cmd_o.emit, sts_i.emit_ok)

endmodule

// File: design/srs_datapath.sv
`include "selective_repeat_sender_defines.svh"

module srs_datapath import srs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srs_cmd_t            cmd_i,
  output srs_sts_t            sts_o,
  input  logic [OP_W-1:0]     in_op_i,
  input  logic [PAY_IO_W-1:0] in_payload_word_i,
  input  logic [SEQ_IO_W-1:0] in_seq_num_i,
  input  logic                in_ack_intact_i,
  input  logic                cfg_valid_i,
  input  logic [WIN_W-1:0]    cfg_window_size_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_accepted_o,
  output logic                out_tx_valid_o,
  output logic [SEQ_IO_W-1:0] out_tx_seq_o,
  output logic [PAY_IO_W-1:0] out_tx_payload_o,
  output logic [ACT_W-1:0]    out_timer_action_o,
  output logic [SEQ_IO_W-1:0] out_timer_seq_o,
  output logic [OUTC_W-1:0]   out_ack_outcome_o,
  output logic                out_window_full_o
);

  // control state
  logic [WIN_W-1:0]    window_size_q;
  logic [SEQ_BITS-1:0] base_q, base_d;
  logic [SEQ_BITS-1:0] next_q, next_d;
  logic                full_q, full_d;
  logic [SLOTS-1:0]    marks_q, marks_d;
  logic                out_valid_q, out_valid_d;

  // captured item and results
  logic [OP_W-1:0]         op_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [SEQ_BITS-1:0]     seq_q;
  logic                    intact_q;
  srs_res_t                res_q, res_d;
  srs_res_t                out_res_q;
  logic                    out_full_q;

  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic                    ram_we;

  logic [CNT_W-1:0]    win;
  logic [SEQ_BITS-1:0] outstanding;
  logic [CNT_W-1:0]    os_ext;
  logic [SEQ_BITS-1:0] ack_dist;
  logic                send_ok;
  logic                ack_in_win;
  srs_kind_e           kind_sel;

  always_comb begin
    if (window_size_q == '0) begin
      win = CNT_W'(1);
    end else if (CNT_W'(window_size_q) > CNT_W'(SLOTS)) begin
      win = CNT_W'(SLOTS);
    end else begin
      win = CNT_W'(window_size_q);
    end
  end

  assign outstanding = next_q - base_q;
  assign os_ext      = {1'b0, outstanding};
  assign ack_dist    = seq_q - base_q;
  assign send_ok     = !full_q && (os_ext < win);
  assign ack_in_win  = intact_q && (ack_dist < outstanding);

  always_comb begin
    if (op_q == OP_ACK && ack_in_win && ack_dist == '0) begin
      kind_sel = KIND_SLIDE;
    end else if (op_q == OP_TIMEOUT) begin
      kind_sel = KIND_READ;
    end else begin
      kind_sel = KIND_PLAIN;
    end
  end
  assign sts_o.kind       = kind_sel;
  assign sts_o.slide_more = (base_q != next_q) && marks_q[slot_of(base_q)];
  assign sts_o.emit_ok    = !out_valid_q || out_ready_i;

  always_comb begin
    base_d      = base_q;
    next_d      = next_q;
    full_d      = full_q;
    marks_d     = marks_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q;
    if (cmd_i.resolve) begin
      res_d = '0;
      unique case (op_q)
        OP_SEND: begin
          if (send_ok) begin
            ram_we                  = 1'b1;
            marks_d[slot_of(next_q)] = 1'b0;
            res_d.accepted          = 1'b1;
            res_d.tx_valid          = 1'b1;
            res_d.tx_seq            = next_q;
            res_d.tx_payload        = pay_q;
            res_d.timer_action      = TMR_START;
            res_d.timer_seq         = next_q;
            next_d                  = next_q + 1'b1;
            if (os_ext + CNT_W'(1) == win) begin
              full_d = 1'b1;
            end
          end
        end
        OP_ACK: begin
          res_d.ack_outcome = ACK_IGNORED;
          if (ack_in_win) begin
            if (ack_dist == '0) begin
              marks_d[slot_of(base_q)] = 1'b1;
              res_d.timer_action       = TMR_STOP;
              res_d.timer_seq          = seq_q;
              res_d.ack_outcome        = ACK_SLID;
            end else if (!marks_q[slot_of(seq_q)]) begin
              marks_d[slot_of(seq_q)] = 1'b1;
              res_d.timer_action      = TMR_STOP;
              res_d.timer_seq         = seq_q;
              res_d.ack_outcome       = ACK_MARKED;
            end
          end
        end
        OP_TIMEOUT: begin
          res_d.tx_valid     = 1'b1;
          res_d.tx_seq       = seq_q;
          res_d.timer_action = TMR_RESTART;
          res_d.timer_seq    = seq_q;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.load_tx) begin
      res_d.tx_payload = ram_rdata;
    end
    if (cmd_i.slide) begin
      marks_d[slot_of(base_q)] = 1'b0;
      base_d                   = base_q + 1'b1;
    end
    if (cmd_i.slide_end) begin
      full_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_RESET;
      base_q        <= '0;
      next_q        <= '0;
      full_q        <= 1'b0;
      marks_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        window_size_q <= cfg_window_size_i;
      end
      base_q      <= base_d;
      next_q      <= next_d;
      full_q      <= full_d;
      marks_q     <= marks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= in_op_i;
      pay_q    <= PAYLOAD_BITS'(in_payload_word_i);
      seq_q    <= SEQ_BITS'(in_seq_num_i);
      intact_q <= in_ack_intact_i;
    end
    res_q <= res_d;
    if (cmd_i.emit) begin
      out_res_q  <= res_q;
      out_full_q <= full_q;
    end
  end

  // store read address follows the captured sequence; read data is registered and lands in the next cycle
  srs_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_of(next_q)),
    .wdata_i (pay_q),
    .raddr_i (slot_of(seq_q)),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o        = out_valid_q;
  assign out_accepted_o     = out_res_q.accepted;
  assign out_tx_valid_o     = out_res_q.tx_valid;
  assign out_tx_seq_o       = SEQ_IO_W'(out_res_q.tx_seq);
  assign out_tx_payload_o   = PAY_IO_W'(out_res_q.tx_payload);
  assign out_timer_action_o = out_res_q.timer_action;
  assign out_timer_seq_o    = SEQ_IO_W'(out_res_q.timer_seq);
  assign out_ack_outcome_o  = out_res_q.ack_outcome;
  assign out_window_full_o  = out_full_q;

  // the full mark drops only at the end of the slide, after the base may have caught up
  `SRS_ASSERT_IMP(a_outstanding_bound, clk_i, rst_ni, 1'b1, os_ext <= CNT_W'(SLOTS))
  `SRS_ASSERT_IMP(a_full_has_outstanding, clk_i, rst_ni, full_q && !cmd_i.slide_end, outstanding != '0)
  `SRS_ASSERT_IMP(a_slide_within_window, clk_i, rst_ni, cmd_i.slide, base_q != next_q)

endmodule

// File: design/selective_repeat_sender.sv
// Sequence: an item is captured, resolved and then emitted into the result register;
//   a timeout also waits for the packet store read, and an ack that slides the base
//   runs the slide loop before the emit, one slot per cycle.
// Items are handled one at a time: the next item is taken once the last is emitted,
//   also while its result waits; emit stalls while the result register is not drained.
// Reset: asynchronous, active low; clears base, next, full mark and acked marks,
//   loads window_size with 4. The packet store is not cleared.
`include "selective_repeat_sender_defines.svh"

module selective_repeat_sender import srs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  srs_in_if.sink   in_ch,
  srs_out_if.source out_ch,
  srs_cfg_if.sink  cfg_ch
);

  srs_cmd_t cmd;
  srs_sts_t sts;

  // register writes are always taken
  assign cfg_ch.ready = 1'b1;

  srs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srs_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_op_i            (in_ch.op),
    .in_payload_word_i  (in_ch.payload_word),
    .in_seq_num_i       (in_ch.seq_num),
    .in_ack_intact_i    (in_ch.ack_intact),
    .cfg_valid_i        (cfg_ch.valid),
    .cfg_window_size_i  (cfg_ch.window_size),
    .out_ready_i        (out_ch.ready),
    .out_valid_o        (out_ch.valid),
    .out_accepted_o     (out_ch.accepted),
    .out_tx_valid_o     (out_ch.tx_valid),
    .out_tx_seq_o       (out_ch.tx_seq),
    .out_tx_payload_o   (out_ch.tx_payload),
    .out_timer_action_o (out_ch.timer_action),
    .out_timer_seq_o    (out_ch.timer_seq),
    .out_ack_outcome_o  (out_ch.ack_outcome),
    .out_window_full_o  (out_ch.window_full)
  );

  `SRS_ASSERT_NEXT(a_send_result_next, clk_i, rst_ni, cmd.emit, out_ch.valid)

endmodule
